>>> src/tgb_pkg.sv
// ----------------------------------------------------------------------------
// Tile glyph blitter package
// Shared types and constants: tile descriptor, configuration set and
// register index codes.
// ----------------------------------------------------------------------------
package tgb_pkg;

    localparam int TILE_SIZE  = 8;
    localparam int TILE_SHIFT = $clog2(TILE_SIZE);
    localparam int PIX_CNT_W  = 2 * TILE_SHIFT;
    localparam int POS_W      = 13;
    localparam int BASE_W     = POS_W + TILE_SHIFT;
    localparam int CALC_W     = 24;
    localparam int COLOR_W    = 32;
    localparam int ADDR_W     = 20;
    localparam int SPAN_W     = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // One accepted tile, position already converted to screen pixels.
    typedef struct packed {
        logic [TILE_SIZE-1:0][TILE_SIZE-1:0] rows;
        logic [COLOR_W-1:0]                  fg_color;
        logic [COLOR_W-1:0]                  bg_color;
        logic signed [BASE_W-1:0]            base_x;
        logic signed [BASE_W-1:0]            base_y;
    } t_tile;

    typedef struct packed {
        logic [10:0] clip_left;
        logic [9:0]  clip_top;
        logic [10:0] clip_right;
        logic [9:0]  clip_bottom;
        logic [4:0]  scale_w;
        logic [4:0]  scale_h;
        logic        transparent_bg;
        logic        grid_mode;
    } t_cfg;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLIP_LEFT      = 3'd0,
        CFG_CLIP_TOP       = 3'd1,
        CFG_CLIP_RIGHT     = 3'd2,
        CFG_CLIP_BOTTOM    = 3'd3,
        CFG_SCALE_W        = 3'd4,
        CFG_SCALE_H        = 3'd5,
        CFG_TRANSPARENT_BG = 3'd6,
        CFG_GRID_MODE      = 3'd7
    } t_cfg_index;

endpackage

>>> src/tgb_front.sv
// ----------------------------------------------------------------------------
// Tile glyph blitter front end
// Accepts tile items, resolves the grid position to pixels and hands the
// tile descriptor to the queue.
// ----------------------------------------------------------------------------
module tgb_front
    import tgb_pkg::*;
(
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_grid_mode,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [TILE_SIZE-1:0][TILE_SIZE-1:0] i_rows,
    input  logic [COLOR_W-1:0]                  i_fg_color,
    input  logic [COLOR_W-1:0]                  i_bg_color,
    input  logic signed [POS_W-1:0]             i_tile_x,
    input  logic signed [POS_W-1:0]             i_tile_y,
    output logic                                o_push,
    output t_tile                               o_tile,
    input  logic                                i_queue_full
);

    logic  r_valid;
    logic  n_valid;
    t_tile r_tile;
    t_tile n_tile;
    logic  accept;

    assign o_in_stall = r_valid && i_queue_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_queue_full;
    assign o_tile     = r_tile;

    always_comb begin
        n_tile.rows     = i_rows;
        n_tile.fg_color = i_fg_color;
        n_tile.bg_color = i_bg_color;
        if (i_grid_mode) begin
            n_tile.base_x = $signed({i_tile_x, {TILE_SHIFT{1'b0}}});
            n_tile.base_y = $signed({i_tile_y, {TILE_SHIFT{1'b0}}});
        end else begin
            n_tile.base_x = BASE_W'(i_tile_x);
            n_tile.base_y = BASE_W'(i_tile_y);
        end
    end

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tile <= n_tile;
        end
    end

endmodule

>>> src/tgb_queue.sv
// ----------------------------------------------------------------------------
// Tile glyph blitter queue
// Two-entry queue of tile descriptors between front end and pixel engine.
// ----------------------------------------------------------------------------
module tgb_queue
    import tgb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_tile i_tile,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_tile o_tile
);

    t_tile      r_entry [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_tile  = r_entry[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !(i_pop && o_valid)) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop && o_valid) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop && o_valid) begin
                r_rptr <= !r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wptr] <= i_tile;
        end
    end

endmodule

>>> src/tgb_back.sv
// ----------------------------------------------------------------------------
// Tile glyph blitter pixel engine
// Walks the 64 pixels of a tile through a three-stage pipeline: scale
// multiply, clip, address multiply. The last stage is the result register.
// ----------------------------------------------------------------------------
module tgb_back
    import tgb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 1280,
    parameter int SCREEN_HEIGHT = 720
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_queue_valid,
    input  t_tile              i_tile,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [ADDR_W-1:0]  o_write_addr,
    output logic [COLOR_W-1:0] o_write_color,
    output logic [SPAN_W-1:0]  o_span_w,
    output logic [SPAN_W-1:0]  o_span_h,
    output logic               o_write_en,
    output logic               o_last
);

    localparam int XW = $clog2((SCREEN_WIDTH > 2047 ? SCREEN_WIDTH : 2047) + 1);
    localparam int YW = $clog2((SCREEN_HEIGHT > 1023 ? SCREEN_HEIGHT : 1023) + 1);
    localparam int AW = (XW + YW + 1 > ADDR_W) ? XW + YW + 1 : ADDR_W;
    localparam int PX_W   = BASE_W + 1;
    localparam int PROD_W = PX_W + 6;

    // Current tile and pixel counter.
    t_tile                r_tile;
    logic                 r_busy;
    logic                 n_busy;
    logic [PIX_CNT_W-1:0] r_cnt;
    logic                 adv;
    logic                 cnt_end;

    // Stage A: scaled offsets.
    logic                     r_a_valid;
    logic signed [PROD_W-1:0] r_a_prod_x;
    logic signed [PROD_W-1:0] r_a_prod_y;
    logic                     r_a_set;
    logic [COLOR_W-1:0]       r_a_color;
    logic                     r_a_last;

    // Stage B: clipped rectangle.
    logic               r_b_valid;
    logic               r_b_en;
    logic [XW-1:0]      r_b_sx;
    logic [YW-1:0]      r_b_sy;
    logic [SPAN_W-1:0]  r_b_w;
    logic [SPAN_W-1:0]  r_b_h;
    logic [COLOR_W-1:0] r_b_color;
    logic               r_b_last;

    // Stage A combinational.
    logic [TILE_SHIFT-1:0]  col;
    logic [TILE_SHIFT-1:0]  row;
    logic signed [PX_W-1:0] px;
    logic signed [PX_W-1:0] py;
    logic                   pix_set;

    // Stage B combinational.
    logic signed [CALC_W-1:0] ax;
    logic signed [CALC_W-1:0] bx;
    logic signed [CALC_W-1:0] ay;
    logic signed [CALC_W-1:0] by;
    logic signed [CALC_W-1:0] lo_x;
    logic signed [CALC_W-1:0] hi_x;
    logic signed [CALC_W-1:0] lo_y;
    logic signed [CALC_W-1:0] hi_y;
    logic signed [CALC_W-1:0] ax_cl;
    logic signed [CALC_W-1:0] bx_cl;
    logic signed [CALC_W-1:0] ay_cl;
    logic signed [CALC_W-1:0] by_cl;
    logic signed [CALC_W-1:0] dx;
    logic signed [CALC_W-1:0] dy;
    logic                     w_pos;
    logic                     h_pos;

    // Stage C combinational.
    logic [AW-1:0] addr_full;

    assign adv     = !o_out_valid || !i_out_stall;
    assign cnt_end = (r_cnt == {PIX_CNT_W{1'b1}});
    assign o_pop   = adv && i_queue_valid && (!r_busy || cnt_end);

    always_comb begin
        if (o_pop) begin
            n_busy = 1'b1;
        end else if (adv && cnt_end) begin
            n_busy = 1'b0;
        end else begin
            n_busy = r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_cnt     <= '0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_busy <= n_busy;
            if (adv) begin
                r_a_valid   <= r_busy;
                r_b_valid   <= r_a_valid;
                o_out_valid <= r_b_valid;
                if (r_busy) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_tile <= i_tile;
        end
    end

    // Stage A: pixel select and scale multiply.
    assign row     = r_cnt[PIX_CNT_W-1:TILE_SHIFT];
    assign col     = r_cnt[TILE_SHIFT-1:0];
    assign pix_set = r_tile.rows[row][~col];
    assign px      = PX_W'(r_tile.base_x) + $signed({1'b0, col});
    assign py      = PX_W'(r_tile.base_y) + $signed({1'b0, row});

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_prod_x <= px * $signed({1'b0, i_cfg.scale_w});
            r_a_prod_y <= py * $signed({1'b0, i_cfg.scale_h});
            r_a_set    <= pix_set;
            r_a_color  <= pix_set ? r_tile.fg_color : r_tile.bg_color;
            r_a_last   <= cnt_end;
        end
    end

    // Stage B: place the rectangle and intersect it with the clip window.
    always_comb begin
        lo_x = CALC_W'($signed({1'b0, i_cfg.clip_left}));
        lo_y = CALC_W'($signed({1'b0, i_cfg.clip_top}));
        if (CALC_W'($signed({1'b0, i_cfg.clip_right})) < CALC_W'(SCREEN_WIDTH)) begin
            hi_x = CALC_W'($signed({1'b0, i_cfg.clip_right}));
        end else begin
            hi_x = CALC_W'(SCREEN_WIDTH);
        end
        if (CALC_W'($signed({1'b0, i_cfg.clip_bottom})) < CALC_W'(SCREEN_HEIGHT)) begin
            hi_y = CALC_W'($signed({1'b0, i_cfg.clip_bottom}));
        end else begin
            hi_y = CALC_W'(SCREEN_HEIGHT);
        end
        ax    = CALC_W'(r_a_prod_x) + lo_x;
        ay    = CALC_W'(r_a_prod_y) + lo_y;
        bx    = ax + CALC_W'($signed({1'b0, i_cfg.scale_w}));
        by    = ay + CALC_W'($signed({1'b0, i_cfg.scale_h}));
        ax_cl = (ax < lo_x) ? lo_x : ax;
        ay_cl = (ay < lo_y) ? lo_y : ay;
        bx_cl = (bx > hi_x) ? hi_x : bx;
        by_cl = (by > hi_y) ? hi_y : by;
        dx    = bx_cl - ax_cl;
        dy    = by_cl - ay_cl;
        w_pos = (dx > 0);
        h_pos = (dy > 0);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_en    <= w_pos && h_pos && (r_a_set || !i_cfg.transparent_bg);
            r_b_sx    <= ax_cl[XW-1:0];
            r_b_sy    <= ay_cl[YW-1:0];
            r_b_w     <= w_pos ? dx[SPAN_W-1:0] : '0;
            r_b_h     <= h_pos ? dy[SPAN_W-1:0] : '0;
            r_b_color <= r_a_color;
            r_b_last  <= r_a_last;
        end
    end

    // Stage C: frame buffer address, disabled results read as zero.
    assign addr_full = AW'(r_b_sy) * AW'(SCREEN_WIDTH) + AW'(r_b_sx);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_write_en    <= r_b_en;
            o_last        <= r_b_last;
            o_write_addr  <= r_b_en ? addr_full[ADDR_W-1:0] : '0;
            o_write_color <= r_b_en ? r_b_color : '0;
            o_span_w      <= r_b_en ? r_b_w : '0;
            o_span_h      <= r_b_en ? r_b_h : '0;
        end
    end

endmodule

>>> src/tile_glyph_blitter.sv
// ----------------------------------------------------------------------------
// Tile glyph blitter
// Expands one 8x8 one-bit tile into 64 clipped, scaled pixel rectangle writes.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (i_in_valid / o_in_stall) takes one tile item: eight
//   row bytes, foreground and background colors and a tile position. The
//   result channel (o_out_valid / i_out_stall) gives 64 items per tile, one
//   per pixel, row 0 first and bit 7 first within a row; o_last marks the
//   64th. Each carries a clipped rectangle, its frame buffer address and
//   its color; o_write_en is low for skipped or fully clipped pixels, and
//   then all other fields except o_last are zero.
//   Throughput is one result per cycle while the result side does not stall;
//   a tile occupies the pixel engine until its counter has walked all 64
//   pixels, and tiles follow each other with no gap while the queue holds
//   the next one. On the way to its first result a tile enters the front
//   register at the accepting edge, then passes the queue, the tile load,
//   scale multiply, clip and address stages. The user must write registers
//   on the config channel (i_cfg_valid / o_cfg_ready, always ready) only while
//   the block is idle; the block itself does not enforce this. Reset empties
//   the front register, the queue and the pipeline and loads the register
//   defaults. A stall on the result side freezes the whole pixel pipeline;
//   the front end and the two-entry queue still take up to three further tiles.
// ----------------------------------------------------------------------------
module tile_glyph_blitter
    import tgb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 1280,
    parameter int SCREEN_HEIGHT = 720
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Tile input channel.
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [7:0]            i_row0_bits,
    input  logic [7:0]            i_row1_bits,
    input  logic [7:0]            i_row2_bits,
    input  logic [7:0]            i_row3_bits,
    input  logic [7:0]            i_row4_bits,
    input  logic [7:0]            i_row5_bits,
    input  logic [7:0]            i_row6_bits,
    input  logic [7:0]            i_row7_bits,
    input  logic [COLOR_W-1:0]    i_fg_color,
    input  logic [COLOR_W-1:0]    i_bg_color,
    input  logic signed [POS_W-1:0] i_tile_x,
    input  logic signed [POS_W-1:0] i_tile_y,
    // Pixel result channel.
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [ADDR_W-1:0]     o_write_addr,
    output logic [COLOR_W-1:0]    o_write_color,
    output logic [SPAN_W-1:0]     o_span_w,
    output logic [SPAN_W-1:0]     o_span_h,
    output logic                  o_write_en,
    output logic                  o_last
);

    t_cfg                                r_cfg;
    logic [TILE_SIZE-1:0][TILE_SIZE-1:0] rows;
    logic                                push;
    t_tile                               front_tile;
    logic                                queue_full;
    logic                                queue_valid;
    t_tile                               queue_tile;
    logic                                pop;

    // The register file never back-pressures.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clip_left      <= 11'd0;
            r_cfg.clip_top       <= 10'd0;
            r_cfg.clip_right     <= 11'd1280;
            r_cfg.clip_bottom    <= 10'd720;
            r_cfg.scale_w        <= 5'd1;
            r_cfg.scale_h        <= 5'd1;
            r_cfg.transparent_bg <= 1'b0;
            r_cfg.grid_mode      <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_CLIP_LEFT: begin
                    r_cfg.clip_left <= i_cfg_data[10:0];
                end
                CFG_CLIP_TOP: begin
                    r_cfg.clip_top <= i_cfg_data[9:0];
                end
                CFG_CLIP_RIGHT: begin
                    r_cfg.clip_right <= i_cfg_data[10:0];
                end
                CFG_CLIP_BOTTOM: begin
                    r_cfg.clip_bottom <= i_cfg_data[9:0];
                end
                CFG_SCALE_W: begin
                    r_cfg.scale_w <= i_cfg_data[4:0];
                end
                CFG_SCALE_H: begin
                    r_cfg.scale_h <= i_cfg_data[4:0];
                end
                CFG_TRANSPARENT_BG: begin
                    r_cfg.transparent_bg <= i_cfg_data[0];
                end
                CFG_GRID_MODE: begin
                    r_cfg.grid_mode <= i_cfg_data[0];
                end
            endcase
        end
    end

    // Row r of the tile sits at index r of the packed row array.
    assign rows[0] = i_row0_bits;
    assign rows[1] = i_row1_bits;
    assign rows[2] = i_row2_bits;
    assign rows[3] = i_row3_bits;
    assign rows[4] = i_row4_bits;
    assign rows[5] = i_row5_bits;
    assign rows[6] = i_row6_bits;
    assign rows[7] = i_row7_bits;

    // Front end: takes the tile and converts a grid position to pixels.
    tgb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_grid_mode  (r_cfg.grid_mode),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_rows       (rows),
        .i_fg_color   (i_fg_color),
        .i_bg_color   (i_bg_color),
        .i_tile_x     (i_tile_x),
        .i_tile_y     (i_tile_y),
        .o_push       (push),
        .o_tile       (front_tile),
        .i_queue_full (queue_full)
    );

    // Queue: lets the front end keep taking tiles while pixels drain.
    tgb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tile  (front_tile),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_tile  (queue_tile)
    );

    // Pixel engine: one pixel rectangle per cycle while the result side does not stall.
    tgb_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_queue_valid (queue_valid),
        .i_tile        (queue_tile),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_write_addr  (o_write_addr),
        .o_write_color (o_write_color),
        .o_span_w      (o_span_w),
        .o_span_h      (o_span_h),
        .o_write_en    (o_write_en),
        .o_last        (o_last)
    );

endmodule
